/* rtl/core/ftdv_pkg.sv */
// Shared types, codes and helper functions for the font table directory validator.
package ftdv_pkg;

    localparam int DEF_MAX_TABLES = 1024;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RESOURCE_SIZE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTORY_START  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_TOTAL      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLLECTION_END   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_RANGE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_SELECTOR   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_SHIFT      = 3'd6;

    // Result status codes
    localparam logic [2:0] STATUS_OK            = 3'd0;
    localparam logic [2:0] STATUS_BAD_TAG       = 3'd1;
    localparam logic [2:0] STATUS_UNSORTED      = 3'd2;
    localparam logic [2:0] STATUS_DUPLICATE     = 3'd3;
    localparam logic [2:0] STATUS_RANGE_ESCAPE  = 3'd4;
    localparam logic [2:0] STATUS_DIR_OVERLAP   = 3'd5;
    localparam logic [2:0] STATUS_TABLE_OVERLAP = 3'd6;
    localparam logic [2:0] STATUS_SKIPPED       = 3'd7;

    localparam logic [7:0]  TAG_MIN          = 8'h20;
    localparam logic [7:0]  TAG_MAX          = 8'h7e;
    localparam logic [15:0] DIR_HEADER_BYTES = 16'd12;
    localparam int          DIR_RECORD_SHIFT = 4;  // 16 bytes per directory record

    typedef struct packed {
        logic        first_record;
        logic [31:0] record_tag;
        logic [31:0] table_start;
        logic [31:0] table_size;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  record_number;
        logic        done_res;
        logic [41:0] payload_total;
        logic [10:0] empty_count;
        logic [10:0] misaligned_count;
        logic        search_match;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;     // capture the input word
        logic check;    // latch the result of the per-record checks
        logic step;     // advance the range store walk
        logic overlap;  // record a table overlap
        logic commit;   // retire the record and load the output register
    } cmd_t;

    typedef struct packed {
        logic early_stop;  // no walk needed: failed, skipped or first record
        logic walk_hit;
        logic walk_end;
        logic out_free;
    } sts_t;

    function automatic logic tag_printable(input logic [31:0] tag);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (tag[8*k +: 8] < TAG_MIN || tag[8*k +: 8] > TAG_MAX) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Compare the header search fields with the values implied by the table count.
    function automatic logic search_fields_match(
        input logic [10:0] count,
        input logic [15:0] range_f,
        input logic [15:0] sel_f,
        input logic [15:0] shift_f
    );
        logic [3:0]  sel;
        logic [15:0] exp_range;
        logic [15:0] exp_shift;
        sel = 4'd0;
        for (int b = 1; b < 11; b++) begin
            if (count[b]) begin
                sel = 4'(b);
            end
        end
        exp_range = 16'd1 << (sel + 4'(DIR_RECORD_SHIFT));
        exp_shift = {1'b0, count, 4'b0000} - exp_range;
        return (range_f == exp_range) && (sel_f == {12'b0, sel}) && (shift_f == exp_shift);
    endfunction

endpackage

/* rtl/core/font_table_directory_validator.sv */
// Top level of the font table directory validator: controller plus datapath.
//
//  channel   direction  handshake             word
//  -------   ---------  --------------------  ---------------------------------------
//  input     in         in_valid / in_stall   in_data: pass mark, tag, offset, length
//  output    out        out_valid / out_stall out_data: status, record number, tallies
//  config    in         cfg_write             cfg_index, cfg_data (no read-back)
//
//  A record goes through the check state and the finish state, and through the walk state
//  too when its tag, range and directory checks pass and it is not the first of its pass:
//  the overlap walk reads one stored range a cycle and stops at the first overlap.
//  in_stall is low only while the controller is idle; the next record is taken while
//  out_stall holds the last word, and its retire waits until that word is taken.
//  Reset clears the controller, the pass state, the tallies and the configuration;
//  the range store has no reset and needs no clearing pass.
module font_table_directory_validator #(
    parameter int MAX_TABLES = ftdv_pkg::DEF_MAX_TABLES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ftdv_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ftdv_pkg::out_word_t                 out_data,
    input  logic                                cfg_write,
    input  logic [ftdv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ftdv_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ftdv_pkg::cmd_t cmd;
    ftdv_pkg::sts_t sts;

    // Controller: accept, check, walk the earlier ranges, retire
    ftdv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: holds the configuration, the range store and the output word
    ftdv_dp #(
        .MAX_TABLES (MAX_TABLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // One record at a time: after a word is taken the input stalls
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a record was in flight");

    // A skipped word never ends a pass and carries record zero
    a_skip_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ftdv_pkg::STATUS_SKIPPED) |->
        (!out_data.done_res && out_data.record_number == '0 && !out_data.search_match))
        else $error("skipped word with pass fields set");

    // Any error ends the pass
    a_error_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ftdv_pkg::STATUS_OK &&
         out_data.status != ftdv_pkg::STATUS_SKIPPED) |-> out_data.done_res)
        else $error("error word without pass end");

    // The search match is reported only on a word that ends the pass
    a_match_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.search_match) |-> out_data.done_res)
        else $error("search match outside pass end");
`endif

endmodule

/* rtl/core/ftdv_ctrl.sv */
// Sequencing state machine for the table directory validator.
module ftdv_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ftdv_pkg::sts_t  sts,
    output ftdv_pkg::cmd_t  cmd
);

    ftdv_pkg::state_t state_reg;
    ftdv_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftdv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ftdv_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ftdv_pkg::ST_CHECK;
                end
            end
            ftdv_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.early_stop)
                begin
                    state_next = ftdv_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ftdv_pkg::ST_WALK;
                end
            end
            ftdv_pkg::ST_WALK:
            begin
                if (sts.walk_hit)
                begin
                    cmd.overlap = 1'b1;
                    state_next  = ftdv_pkg::ST_FINISH;
                end
                else if (sts.walk_end)
                begin
                    state_next = ftdv_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ftdv_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ftdv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftdv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ftdv_dp.sv */
// Datapath: configuration, record checks, range store, tallies and output register.
module ftdv_dp #(
    parameter int MAX_TABLES = ftdv_pkg::DEF_MAX_TABLES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ftdv_pkg::in_word_t                  in_data,
    input  ftdv_pkg::cmd_t                      cmd,
    output ftdv_pkg::sts_t                      sts,
    input  logic                                cfg_write,
    input  logic [ftdv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ftdv_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ftdv_pkg::out_word_t                 out_data
);

    localparam int AW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int CW = $clog2(MAX_TABLES + 1);

    // Configuration registers
    logic [31:0] resource_size_reg;
    logic [31:0] directory_start_reg;
    logic [10:0] table_total_reg;
    logic [18:0] coll_end_reg;
    logic [15:0] hdr_range_reg;
    logic [15:0] hdr_sel_reg;
    logic [15:0] hdr_shift_reg;

    // Pass state
    logic          pass_active_reg;
    logic [CW-1:0] rec_cnt_reg;
    logic [31:0]   last_tag_reg;
    logic [42:0]   byte_sum_reg;
    logic [10:0]   empty_reg;
    logic [10:0]   misal_reg;

    // Record in flight
    ftdv_pkg::in_word_t item_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      walk_addr_reg;
    logic [2:0]         status_reg;
    logic               search_ok_reg;

    logic [63:0] range_mem [MAX_TABLES];
    logic [63:0] rd_data_reg;

    ftdv_pkg::out_word_t out_data_reg;
    logic                out_valid_reg;

    logic [10:0]   count;
    logic [AW-1:0] idx_load;
    logic [32:0]   item_end;
    logic [32:0]   dir_end;
    logic [15:0]   dir_len;
    logic          dir_meet;
    logic          coll_meet;
    logic [2:0]    pre_status;
    logic [31:0]   ent_start;
    logic [31:0]   ent_size;
    logic [32:0]   ent_end;
    logic          is_last;
    logic          rec_ok;
    logic          rec_done;
    logic [42:0]   byte_sum_next;
    logic [10:0]   empty_next;
    logic [10:0]   misal_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resource_size_reg   <= '0;
            directory_start_reg <= '0;
            table_total_reg     <= 11'd1;
            coll_end_reg        <= '0;
            hdr_range_reg       <= '0;
            hdr_sel_reg         <= '0;
            hdr_shift_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ftdv_pkg::CFG_RESOURCE_SIZE:   resource_size_reg   <= cfg_data;
                ftdv_pkg::CFG_DIRECTORY_START: directory_start_reg <= cfg_data;
                ftdv_pkg::CFG_TABLE_TOTAL:     table_total_reg     <= cfg_data[10:0];
                ftdv_pkg::CFG_COLLECTION_END:  coll_end_reg        <= cfg_data[18:0];
                ftdv_pkg::CFG_SEARCH_RANGE:    hdr_range_reg       <= cfg_data[15:0];
                ftdv_pkg::CFG_ENTRY_SELECTOR:  hdr_sel_reg         <= cfg_data[15:0];
                ftdv_pkg::CFG_RANGE_SHIFT:     hdr_shift_reg       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Clamp the table count to 1..MAX_TABLES
    always_comb
    begin
        count = table_total_reg;
        if (count == 11'd0)
        begin
            count = 11'd1;
        end
        if (32'(count) > 32'(MAX_TABLES))
        begin
            count = 11'(MAX_TABLES);
        end
    end

    always_comb
    begin
        if (in_data.first_record)
        begin
            idx_load = '0;
        end
        else if (32'(rec_cnt_reg) >= 32'(count))
        begin
            idx_load = AW'(32'(count) - 32'd1);
        end
        else
        begin
            idx_load = AW'(rec_cnt_reg);
        end
    end

    // Per-record checks, in priority order
    always_comb
    begin
        item_end  = {1'b0, item_reg.table_start} + {1'b0, item_reg.table_size};
        dir_len   = ftdv_pkg::DIR_HEADER_BYTES + {1'b0, count, 4'b0000};
        dir_end   = {1'b0, directory_start_reg} + {17'b0, dir_len};
        dir_meet  = ({1'b0, item_reg.table_start} < dir_end) &&
                    ({1'b0, directory_start_reg} < item_end);
        coll_meet = (coll_end_reg != 19'd0) &&
                    (item_reg.table_start < {13'b0, coll_end_reg});
        if (!pass_active_reg)
        begin
            pre_status = ftdv_pkg::STATUS_SKIPPED;
        end
        else if (!ftdv_pkg::tag_printable(item_reg.record_tag))
        begin
            pre_status = ftdv_pkg::STATUS_BAD_TAG;
        end
        else if (idx_reg != '0 && item_reg.record_tag <= last_tag_reg)
        begin
            pre_status = (item_reg.record_tag == last_tag_reg) ?
                         ftdv_pkg::STATUS_DUPLICATE : ftdv_pkg::STATUS_UNSORTED;
        end
        else if (item_end > {1'b0, resource_size_reg})
        begin
            pre_status = ftdv_pkg::STATUS_RANGE_ESCAPE;
        end
        else if (item_reg.table_size != 32'd0 && (dir_meet || coll_meet))
        begin
            pre_status = ftdv_pkg::STATUS_DIR_OVERLAP;
        end
        else
        begin
            pre_status = ftdv_pkg::STATUS_OK;
        end
    end

    // Overlap test against the entry read out of the range store
    assign ent_start = rd_data_reg[63:32];
    assign ent_size  = rd_data_reg[31:0];
    assign ent_end   = {1'b0, ent_start} + {1'b0, ent_size};

    assign sts.early_stop = (pre_status != ftdv_pkg::STATUS_OK) || (idx_reg == '0);
    assign sts.walk_hit   = (item_reg.table_size != 32'd0) && (ent_size != 32'd0) &&
                            ({1'b0, item_reg.table_start} < ent_end) &&
                            ({1'b0, ent_start} < item_end);
    assign sts.walk_end   = (walk_addr_reg == idx_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // Retire values
    always_comb
    begin
        is_last       = (32'(idx_reg) == 32'(count) - 32'd1);
        rec_ok        = (status_reg == ftdv_pkg::STATUS_OK);
        rec_done      = is_last || !rec_ok;
        byte_sum_next = byte_sum_reg;
        empty_next    = empty_reg;
        misal_next    = misal_reg;
        if (rec_ok)
        begin
            byte_sum_next = byte_sum_reg + {11'b0, item_reg.table_size};
            if (item_reg.table_size == 32'd0)
            begin
                empty_next = empty_reg + 11'd1;
            end
            else if (item_reg.table_start[1:0] != 2'b00)
            begin
                misal_next = misal_reg + 11'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_active_reg <= 1'b0;
            rec_cnt_reg     <= '0;
            last_tag_reg    <= '0;
            byte_sum_reg    <= '0;
            empty_reg       <= '0;
            misal_reg       <= '0;
        end
        else if (cmd.load && in_data.first_record)
        begin
            pass_active_reg <= 1'b1;
            rec_cnt_reg     <= '0;
            last_tag_reg    <= '0;
            byte_sum_reg    <= '0;
            empty_reg       <= '0;
            misal_reg       <= '0;
        end
        else if (cmd.commit && pass_active_reg)
        begin
            byte_sum_reg <= byte_sum_next;
            empty_reg    <= empty_next;
            misal_reg    <= misal_next;
            if (rec_ok)
            begin
                last_tag_reg <= item_reg.record_tag;
            end
            if (rec_done)
            begin
                pass_active_reg <= 1'b0;
            end
            else
            begin
                rec_cnt_reg <= CW'(32'(idx_reg) + 32'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        search_ok_reg <= ftdv_pkg::search_fields_match(count, hdr_range_reg,
                                                       hdr_sel_reg, hdr_shift_reg);
        if (cmd.load)
        begin
            item_reg <= in_data;
            idx_reg  <= idx_load;
        end
        if (cmd.check)
        begin
            status_reg <= pre_status;
        end
        else if (cmd.overlap)
        begin
            status_reg <= ftdv_pkg::STATUS_TABLE_OVERLAP;
        end
        if (cmd.load)
        begin
            walk_addr_reg <= '0;
        end
        else if (cmd.step)
        begin
            walk_addr_reg <= walk_addr_reg + AW'(1);
        end
    end

    // Range store: one write at the retire of a clean record, one registered read per cycle for the walk
    always_ff @(posedge clk)
    begin
        if (cmd.commit && status_reg == ftdv_pkg::STATUS_OK)
        begin
            range_mem[idx_reg] <= {item_reg.table_start, item_reg.table_size};
        end
        rd_data_reg <= range_mem[walk_addr_reg];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg.payload_total    <= byte_sum_next[41:0];
            out_data_reg.empty_count      <= empty_next;
            out_data_reg.misaligned_count <= misal_next;
            if (pass_active_reg)
            begin
                out_data_reg.status        <= status_reg;
                out_data_reg.record_number <= 10'(idx_reg);
                out_data_reg.done_res      <= rec_done;
                out_data_reg.search_match  <= is_last && search_ok_reg;
            end
            else
            begin
                out_data_reg.status        <= ftdv_pkg::STATUS_SKIPPED;
                out_data_reg.record_number <= '0;
                out_data_reg.done_res      <= 1'b0;
                out_data_reg.search_match  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* bench/font_table_directory_validator_tb.sv */
// Self-checking testbench for the font table directory validator: directed and random records.
`timescale 1ns / 100ps

module testbench;

    // Shapes of broken records that the random passes inject
    typedef enum int {
        FAULT_TAG,
        FAULT_ORDER,
        FAULT_DUP,
        FAULT_ESCAPE,
        FAULT_DIR,
        FAULT_COLL,
        FAULT_OVERLAP
    } fault_kind_t;

    localparam int RANDOM_RECORDS = 400;
    localparam int MAX_SENT       = 48;     // longest pass that is sent in full
    localparam int LAYOUT_BUDGET  = 13000;  // bytes reserved for one pass of tables

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    ftdv_pkg::in_word_t                   in_data = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    ftdv_pkg::out_word_t                  out_data;
    logic                                 cfg_write = 1'b0;
    logic [ftdv_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [ftdv_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    font_table_directory_validator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies held by the predictor, at their reset values
    logic [31:0] reg_resource  = '0;
    logic [31:0] reg_dir_start = '0;
    logic [10:0] reg_total     = 11'd1;
    logic [18:0] reg_coll_end  = '0;
    logic [15:0] reg_srange    = '0;
    logic [15:0] reg_esel      = '0;
    logic [15:0] reg_rshift    = '0;

    // Pass state of the predictor
    logic        pass_open       = 1'b0;
    logic [10:0] rec_index       = '0;
    logic [31:0] prev_tag        = '0;
    logic [31:0] span_base [ftdv_pkg::DEF_MAX_TABLES];
    logic [31:0] span_len  [ftdv_pkg::DEF_MAX_TABLES];
    logic [42:0] bytes_seen      = '0;
    logic [10:0] empty_seen      = '0;
    logic [10:0] misaligned_seen = '0;

    // Words predicted at acceptance, oldest first
    ftdv_pkg::out_word_t expected_results [$];
    int                  fail_count = 0;

    // Idle control: quiet turns off the gaps on both sides
    logic quiet = 1'b0;
    int   stall_left = 0;

    // Layout of the last programmed directory, for passes that keep the registers
    logic        lay_valid = 1'b0;
    logic [10:0] lay_total;
    logic [31:0] lay_res;
    logic [31:0] lay_dstart;
    logic [18:0] lay_coll;
    logic [31:0] lay_base;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [10:0] clamp_count(input logic [10:0] total);
        if (total == 11'd0)
            return 11'd1;
        if (total > 11'(ftdv_pkg::DEF_MAX_TABLES))
            return 11'(ftdv_pkg::DEF_MAX_TABLES);
        return total;
    endfunction

    function automatic logic tag_is_printable(input logic [31:0] tag);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            if (tag[8*k +: 8] < 8'h20 || tag[8*k +: 8] > 8'h7e)
                ok = 1'b0;
        end
        return ok;
    endfunction

    // Two byte spans meet only when both are non-empty and they intersect
    function automatic logic spans_touch(input logic [63:0] a0, input logic [63:0] alen,
                                         input logic [63:0] b0, input logic [63:0] blen);
        if (alen == 64'd0 || blen == 64'd0)
            return 1'b0;
        return (a0 < b0 + blen) && (b0 < a0 + alen);
    endfunction

    // Search range, entry selector and range shift implied by a table count
    function automatic void derive_search(input logic [10:0] cnt, output logic [15:0] rng,
                                          output logic [15:0] sel, output logic [15:0] sh);
        int unsigned pow;
        int unsigned lg;
        pow = 1;
        lg  = 0;
        while (pow * 2 <= cnt)
        begin
            pow = pow * 2;
            lg++;
        end
        rng = 16'(pow * 16);
        sel = 16'(lg);
        sh  = 16'(32'(cnt) * 16 - pow * 16);
    endfunction

    function automatic logic header_fields_agree(input logic [10:0] cnt);
        logic [15:0] rng;
        logic [15:0] sel;
        logic [15:0] sh;
        derive_search(cnt, rng, sel, sh);
        return reg_srange == rng && reg_esel == sel && reg_rshift == sh;
    endfunction

    // Advance the predictor by one accepted record and return the word it must produce
    function automatic ftdv_pkg::out_word_t predict_record(input ftdv_pkg::in_word_t w);
        ftdv_pkg::out_word_t r;
        logic [10:0]         cnt;
        logic [10:0]         idx;
        logic [63:0]         st;
        logic [63:0]         sz;
        logic [63:0]         dir_len;
        logic [2:0]          code;
        logic                last;
        int                  k;
        st  = {32'b0, w.table_start};
        sz  = {32'b0, w.table_size};
        cnt = clamp_count(reg_total);
        r   = '0;
        if (w.first_record)
        begin
            pass_open       = 1'b1;
            rec_index       = '0;
            prev_tag        = '0;
            bytes_seen      = '0;
            empty_seen      = '0;
            misaligned_seen = '0;
        end
        if (!pass_open)
        begin
            r.status           = ftdv_pkg::STATUS_SKIPPED;
            r.payload_total    = bytes_seen[41:0];
            r.empty_count      = empty_seen;
            r.misaligned_count = misaligned_seen;
            return r;
        end
        // A counter past the table count stays on the last record
        idx     = (rec_index >= cnt) ? cnt - 11'd1 : rec_index;
        dir_len = 64'd12 + 64'd16 * cnt;
        code    = ftdv_pkg::STATUS_OK;
        if (!tag_is_printable(w.record_tag))
            code = ftdv_pkg::STATUS_BAD_TAG;
        else if (idx != 0 && w.record_tag <= prev_tag)
            code = (w.record_tag == prev_tag) ? ftdv_pkg::STATUS_DUPLICATE :
                                                ftdv_pkg::STATUS_UNSORTED;
        else if (st + sz > {32'b0, reg_resource})
            code = ftdv_pkg::STATUS_RANGE_ESCAPE;
        else if (sz != 0 && (spans_touch(st, sz, {32'b0, reg_dir_start}, dir_len) ||
                             spans_touch(st, sz, 64'd0, {45'b0, reg_coll_end})))
            code = ftdv_pkg::STATUS_DIR_OVERLAP;
        else
        begin
            for (k = 0; k < idx; k++)
            begin
                if (spans_touch(st, sz, {32'b0, span_base[k[9:0]]},
                                {32'b0, span_len[k[9:0]]}))
                begin
                    code = ftdv_pkg::STATUS_TABLE_OVERLAP;
                    break;
                end
            end
        end
        // Only a clean record enters the store and the tallies
        if (code == ftdv_pkg::STATUS_OK)
        begin
            prev_tag            = w.record_tag;
            span_base[idx[9:0]] = w.table_start;
            span_len[idx[9:0]]  = w.table_size;
            bytes_seen          = bytes_seen + sz[42:0];
            if (sz == 0)
                empty_seen = empty_seen + 11'd1;
            else if (st[1:0] != 2'b00)
                misaligned_seen = misaligned_seen + 11'd1;
        end
        last = (idx == cnt - 11'd1);
        r.search_match = last ? header_fields_agree(cnt) : 1'b0;
        if (last || code != ftdv_pkg::STATUS_OK)
            pass_open = 1'b0;
        else
            rec_index = idx + 11'd1;
        r.status           = code;
        r.record_number    = idx[9:0];
        r.done_res         = last || code != ftdv_pkg::STATUS_OK;
        r.payload_total    = bytes_seen[41:0];
        r.empty_count      = empty_seen;
        r.misaligned_count = misaligned_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return idle_span();
    endfunction

    // ------------------------------------------------------------------
    // Result side: check each accepted word and drive the stall
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        ftdv_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: 0x%0h", out_data);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(out_data.status));
                check_field("record_number", 64'(want.record_number),
                            64'(out_data.record_number));
                check_field("done_res", 64'(want.done_res), 64'(out_data.done_res));
                check_field("payload_total", 64'(want.payload_total),
                            64'(out_data.payload_total));
                check_field("empty_count", 64'(want.empty_count),
                            64'(out_data.empty_count));
                check_field("misaligned_count", 64'(want.misaligned_count),
                            64'(out_data.misaligned_count));
                check_field("search_match", 64'(want.search_match),
                            64'(out_data.search_match));
            end
        end
        // Hold off the result channel in runs of random length
        if (quiet)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left = idle_span() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Record side and register writes
    // ------------------------------------------------------------------

    // Offer one record word, hold it until taken, then predict its result.
    // Valid stays high when the next word follows without a gap.
    task automatic send_record(input ftdv_pkg::in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_record(w));
    endtask

    function automatic ftdv_pkg::in_word_t make_record(input logic first,
                                                       input logic [31:0] tag,
                                                       input logic [31:0] start,
                                                       input logic [31:0] size);
        ftdv_pkg::in_word_t w;
        w.first_record = first;
        w.record_tag   = tag;
        w.table_start  = start;
        w.table_size   = size;
        return w;
    endfunction

    // Drop valid and wait until every predicted word has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Leave the write enable high; the caller lowers it after the last register
    task automatic write_reg(input logic [ftdv_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Program all registers once the block has gone idle
    task automatic program_directory(input logic [31:0] res, input logic [31:0] dstart,
                                     input logic [10:0] total, input logic [18:0] coll,
                                     input logic [15:0] srange, input logic [15:0] esel,
                                     input logic [15:0] rshift);
        wait_idle();
        write_reg(ftdv_pkg::CFG_RESOURCE_SIZE, res);
        write_reg(ftdv_pkg::CFG_DIRECTORY_START, dstart);
        write_reg(ftdv_pkg::CFG_TABLE_TOTAL, {21'b0, total});
        write_reg(ftdv_pkg::CFG_COLLECTION_END, {13'b0, coll});
        write_reg(ftdv_pkg::CFG_SEARCH_RANGE, {16'b0, srange});
        write_reg(ftdv_pkg::CFG_ENTRY_SELECTOR, {16'b0, esel});
        write_reg(ftdv_pkg::CFG_RANGE_SHIFT, {16'b0, rshift});
        cfg_write <= 1'b0;
        reg_resource  = res;
        reg_dir_start = dstart;
        reg_total     = total;
        reg_coll_end  = coll;
        reg_srange    = srange;
        reg_esel      = esel;
        reg_rshift    = rshift;
    endtask

    // Printable tag whose order follows n: four base-95 digits, most significant first
    function automatic logic [31:0] printable_tag(input int unsigned n);
        return {8'(8'h20 + (n / 857375) % 95), 8'(8'h20 + (n / 9025) % 95),
                8'(8'h20 + (n / 95) % 95), 8'(8'h20 + n % 95)};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Records with no pass running are skipped and leave the tallies alone
    task automatic test_skip_when_idle();
        send_record(make_record(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_record(make_record(1'b0, 32'h0, 32'h0, 32'h0));
    endtask

    // A table count of zero acts as one: the first record ends the pass
    task automatic test_single_table_pass();
        logic [15:0] sr;
        logic [15:0] es;
        logic [15:0] rs;
        derive_search(11'd1, sr, es, rs);
        program_directory(32'hffff_ffff, 32'h0, 11'd0, 19'd0, sr, es, rs);
        send_record(make_record(1'b1, "head", 32'h100, 32'h10));
        send_record(make_record(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    endtask

    // Walk through every status code but the skipped one with hand-built passes
    task automatic test_status_codes();
        logic [15:0] sr;
        logic [15:0] es;
        logic [15:0] rs;
        derive_search(11'd8, sr, es, rs);
        // directory at 0x800..0x88b, collection header below 0x40
        program_directory(32'h1000, 32'h800, 11'd8, 19'h40, sr, es, rs);
        // empty table, misaligned table, then a repeated tag
        send_record(make_record(1'b1, "cmap", 32'h200, 32'h0));
        send_record(make_record(1'b0, "glyf", 32'h301, 32'h20));
        send_record(make_record(1'b0, "glyf", 32'h400, 32'h4));
        // tag going backward
        send_record(make_record(1'b1, "head", 32'h200, 32'h10));
        send_record(make_record(1'b0, "cmap", 32'h300, 32'h4));
        // control byte first, delete byte last
        send_record(make_record(1'b1, 32'h1f41_4141, 32'h100, 32'h4));
        send_record(make_record(1'b1, 32'h4141_417f, 32'h100, 32'h4));
        // exact fit at the end of the resource, then one byte past it
        send_record(make_record(1'b1, "OS/2", 32'hf00, 32'h100));
        send_record(make_record(1'b1, "OS/2", 32'hf00, 32'h101));
        // inside the face directory, then inside the collection header
        send_record(make_record(1'b1, "OS/2", 32'h810, 32'h4));
        send_record(make_record(1'b1, "OS/2", 32'h3c, 32'h8));
        // an empty table may sit in the directory; the third table hits the second
        send_record(make_record(1'b1, "aaaa", 32'h804, 32'h0));
        send_record(make_record(1'b0, "bbbb", 32'h100, 32'h40));
        send_record(make_record(1'b0, "cccc", 32'h13f, 32'h1));
    endtask

    // Registers at their extremes; a table count above the maximum is clamped
    task automatic test_register_extremes();
        logic [15:0] sr;
        logic [15:0] es;
        logic [15:0] rs;
        program_directory(32'hffff_ffff, 32'hffff_ffff, 11'h7ff, 19'd262164,
                          16'hffff, 16'hffff, 16'hffff);
        send_record(make_record(1'b1, 32'h2020_2020, 32'd262164, 32'h1));
        send_record(make_record(1'b0, 32'h7e7e_7e7e, 32'hffff_fff0, 32'hf));
        send_record(make_record(1'b0, 32'h7e7e_7e7e, 32'h0, 32'h0));
        // empty resource: only an empty table at offset zero fits
        derive_search(11'd1, sr, es, rs);
        program_directory(32'h0, 32'h0, 11'd1, 19'd0, sr, es, rs);
        send_record(make_record(1'b1, "head", 32'h0, 32'h0));
    endtask

    // Fully random words, mostly broken records or skipped ones
    task automatic run_noise_burst();
        ftdv_pkg::in_word_t w;
        int                 n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            w.first_record = 1'($urandom_range(0, 1));
            w.record_tag   = $urandom;
            w.table_start  = $urandom;
            w.table_size   = $urandom;
            send_record(w);
        end
    endtask

    // One well-formed directory with random content, perhaps broken at one record
    task automatic run_directory_pass(inout int unsigned sent);
        logic [10:0]         total;
        logic [10:0]         cnt;
        logic [31:0]         dir_len;
        logic [31:0]         pos;
        logic [31:0]         edge_lo;
        logic [15:0]         sr;
        logic [15:0]         es;
        logic [15:0]         rs;
        logic [31:0]         st_list [MAX_SENT];
        logic [31:0]         sz_list [MAX_SENT];
        ftdv_pkg::in_word_t  w;
        fault_kind_t         kind;
        int                  placed;
        int                  n_send;
        int                  fault_at;
        int                  r;
        int                  j;
        int unsigned         tag_n;
        int unsigned         prev_n;
        if (!lay_valid || $urandom_range(0, 99) < 70)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                total = 11'd0;
            else if (r < 8)
                total = 11'($urandom_range(ftdv_pkg::DEF_MAX_TABLES + 1, 2047));
            else if (r < 10)
                total = 11'(ftdv_pkg::DEF_MAX_TABLES);
            else if (r < 75)
                total = 11'($urandom_range(1, 8));
            else if (r < 95)
                total = 11'($urandom_range(9, 24));
            else
                total = 11'($urandom_range(25, MAX_SENT));
            cnt     = clamp_count(total);
            dir_len = 32'd12 + 32'd16 * cnt;
            r = $urandom_range(0, 99);
            if (r < 25)
                lay_dstart = 32'h0;
            else if (r < 75)
                lay_dstart = $urandom_range(0, 4096);
            else
                lay_dstart = $urandom_range(0, 32'hf000_0000);
            lay_coll = ($urandom_range(0, 1) == 0) ? 19'd0 : 19'($urandom_range(1, 262164));
            // tables go after both the directory and the collection header
            edge_lo  = lay_dstart + dir_len;
            if ({13'b0, lay_coll} > edge_lo)
                edge_lo = {13'b0, lay_coll};
            lay_base = edge_lo + $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0)
                lay_res = 32'hffff_ffff;
            else
                lay_res = lay_base + LAYOUT_BUDGET + $urandom_range(0, 64);
            derive_search(cnt, sr, es, rs);
            // now and then one search field is off by a bit
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: sr[4'($urandom_range(0, 15))] ^= 1'b1;
                    1: es[4'($urandom_range(0, 15))] ^= 1'b1;
                    default: rs[4'($urandom_range(0, 15))] ^= 1'b1;
                endcase
            end
            program_directory(lay_res, lay_dstart, total, lay_coll, sr, es, rs);
            lay_total = total;
            lay_valid = 1'b1;
        end
        cnt     = clamp_count(lay_total);
        dir_len = 32'd12 + 32'd16 * cnt;
        n_send  = (cnt <= MAX_SENT) ? int'(cnt) : $urandom_range(1, 8);
        // leave some passes open; the next pass mark restarts them
        if ($urandom_range(0, 9) == 0)
            n_send = $urandom_range(1, n_send);
        fault_at = ($urandom_range(0, 99) < 35) ? $urandom_range(0, n_send - 1) : -1;
        kind     = fault_kind_t'($urandom_range(FAULT_TAG, FAULT_OVERLAP));
        quiet    = ($urandom_range(0, 4) == 0);
        tag_n    = $urandom_range(1000, 20000000);
        pos      = lay_base;
        placed   = 0;
        for (int i = 0; i < n_send; i++)
        begin
            prev_n = tag_n;
            tag_n  = tag_n + $urandom_range(1, 2000);
            w.first_record = (i == 0) || ($urandom_range(0, 99) < 2);
            w.record_tag   = printable_tag(tag_n);
            if ($urandom_range(0, 99) < 15)
            begin
                w.table_size  = 32'h0;
                w.table_start = ($urandom_range(0, 1) == 0) ? $urandom_range(0, lay_res) : pos;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    pos = (pos + 32'd3) & ~32'd3;
                else
                    pos = pos + $urandom_range(0, 3);
                w.table_start = pos;
                w.table_size  = $urandom_range(1, 256);
                pos = pos + w.table_size;
            end
            if (i == fault_at)
            begin
                case (kind)
                    FAULT_TAG:
                    begin
                        j = $urandom_range(0, 3);
                        w.record_tag[8*j +: 8] = ($urandom_range(0, 1) == 0) ?
                                                 8'($urandom_range(0, 31)) :
                                                 8'($urandom_range(127, 255));
                    end
                    FAULT_ORDER:
                        w.record_tag = printable_tag(prev_n - $urandom_range(1, 500));
                    FAULT_DUP:
                        w.record_tag = printable_tag(prev_n);
                    FAULT_ESCAPE:
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            w.table_start = lay_res - $urandom_range(0, 16);
                            w.table_size  = $urandom_range(17, 300);
                        end
                        else
                        begin
                            // start plus length carries past 32 bits
                            w.table_start = 32'hffff_ffff - $urandom_range(0, 3);
                            w.table_size  = $urandom_range(5, 32'h8000_0000);
                        end
                    end
                    FAULT_COLL:
                    begin
                        if (lay_coll != 19'd0)
                            w.table_start = $urandom_range(0, lay_coll - 1);
                        else
                            w.table_start = lay_dstart + $urandom_range(0, dir_len - 1);
                        w.table_size = $urandom_range(1, 32);
                    end
                    FAULT_OVERLAP:
                    begin
                        if (placed > 0)
                        begin
                            j = $urandom_range(0, placed - 1);
                            w.table_start = st_list[j[5:0]] +
                                            $urandom_range(0, sz_list[j[5:0]] - 1);
                            w.table_size  = $urandom_range(1, 64);
                        end
                    end
                    default:
                    begin
                        w.table_start = lay_dstart + $urandom_range(0, dir_len - 1);
                        w.table_size  = $urandom_range(1, 64);
                    end
                endcase
            end
            else if (w.table_size != 0)
            begin
                st_list[placed[5:0]] = w.table_start;
                sz_list[placed[5:0]] = w.table_size;
                placed++;
            end
            send_record(w);
            sent++;
            if (i == fault_at)
                break;
        end
        // a pass that has ended skips what follows until the next pass mark
        if (!pass_open && $urandom_range(0, 99) < 30)
        begin
            w.first_record = 1'b0;
            w.record_tag   = $urandom;
            w.table_start  = $urandom;
            w.table_size   = $urandom;
            send_record(w);
        end
    endtask

    task automatic test_random_directories();
        int unsigned sent;
        sent = 0;
        while (sent < RANDOM_RECORDS)
        begin
            if ($urandom_range(0, 99) < 10)
                run_noise_burst();
            else
                run_directory_pass(sent);
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_skip_when_idle();
        test_single_table_pass();
        test_status_codes();
        test_register_extremes();
        test_random_directories();
        // drain, then give a stray word time to show up
        wait_idle();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
